FILE: hdl/dspm_pkg.sv
// ----------------------------------------------------------------------------
// Dot-star matcher package
// Shared constants, register map and cell control type for the matcher.
// ----------------------------------------------------------------------------
package dspm_pkg;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] DOT_CHAR  = 8'h2E;

	// Register map: 64-bit registers at byte address 8*i.
	localparam int unsigned DATA_W     = 64;
	localparam int unsigned ADDR_W     = 6;
	localparam int unsigned PAT_REGS   = 4;
	localparam int unsigned PAT_BYTES  = 8 * PAT_REGS;
	localparam int unsigned LEN_W      = 6;

	typedef enum logic [2:0] {
		REG_PAT_LOW      = 3'd0,
		REG_PAT_MID_LOW  = 3'd1,
		REG_PAT_MID_HIGH = 3'd2,
		REG_PAT_HIGH     = 3'd3,
		REG_PAT_LENGTH   = 3'd4
	} reg_index_t;

	// Pattern view of one cell: its own byte, the byte before it, and flags.
	typedef struct packed {
		logic [7:0] self_char;
		logic [7:0] prev_char;
		logic       active;
		logic       has_prev;
	} cell_pat_t;

endpackage

FILE: hdl/dspm_cell.sv
// ----------------------------------------------------------------------------
// Dot-star matcher cell
// Holds the update rule for one pattern position of the match row.
// ----------------------------------------------------------------------------
module dspm_cell (
	input  dspm_pkg::cell_pat_t pat,
	input  logic [7:0]          text_char,
	input  logic                base_prev,
	input  logic                base_self,
	input  logic                new_prev2,
	input  logic                empty_prev2,
	output logic                new_bit,
	output logic                empty_bit
);
	import dspm_pkg::*;

	logic is_star;
	logic hit_self;
	logic hit_prev;

	assign is_star  = (pat.self_char == STAR_CHAR);
	assign hit_self = (pat.self_char == DOT_CHAR) || (pat.self_char == text_char);
	assign hit_prev = (pat.prev_char == DOT_CHAR) || (pat.prev_char == text_char);

	always_comb begin
		new_bit   = 1'b0;
		empty_bit = 1'b0;
		if (pat.active) begin
			if (is_star) begin
				// A star either skips its element or eats one more byte of it.
				new_bit   = pat.has_prev & (new_prev2 | (hit_prev & base_self));
				empty_bit = pat.has_prev & empty_prev2;
			end else begin
				new_bit = hit_self & base_prev;
			end
		end
	end

endmodule

FILE: hdl/dspm_row.sv
// ----------------------------------------------------------------------------
// Dot-star matcher row
// Chain of cells, one per pattern position, producing the next match row and
// the empty-text row of the current pattern.
// ----------------------------------------------------------------------------
module dspm_row #(
	parameter int unsigned PATTERN_MAX = 32
) (
	input  logic [8*PATTERN_MAX-1:0]         pat_bytes,
	input  logic [$clog2(PATTERN_MAX+1)-1:0] used_len,
	input  logic [7:0]                       text_char,
	input  logic [PATTERN_MAX:0]             base_row,
	output logic [PATTERN_MAX:0]             next_row,
	output logic [PATTERN_MAX:0]             empty_row
);
	import dspm_pkg::*;

	localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

	assign next_row[0]  = 1'b0;
	assign empty_row[0] = 1'b1;

	for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
		cell_pat_t pat;
		logic      new_prev2;
		logic      empty_prev2;

		assign pat.self_char = pat_bytes[8*(j-1) +: 8];
		assign pat.active    = (used_len >= LW'(j));
		if (j >= 2) begin : g_prev
			assign pat.prev_char = pat_bytes[8*(j-2) +: 8];
			assign pat.has_prev  = 1'b1;
			assign new_prev2     = next_row[j-2];
			assign empty_prev2   = empty_row[j-2];
		end else begin : g_first
			// A star in the first position has nothing to repeat.
			assign pat.prev_char = 8'h00;
			assign pat.has_prev  = 1'b0;
			assign new_prev2     = 1'b0;
			assign empty_prev2   = 1'b0;
		end

		dspm_cell u_cell (
			.pat         (pat),
			.text_char   (text_char),
			.base_prev   (base_row[j-1]),
			.base_self   (base_row[j]),
			.new_prev2   (new_prev2),
			.empty_prev2 (empty_prev2),
			.new_bit     (next_row[j]),
			.empty_bit   (empty_row[j])
		);
	end

endmodule

FILE: hdl/dot_star_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// Dot-star pattern matcher core
// Whole-string match of streamed text against a configured '.'/'*' pattern.
// ----------------------------------------------------------------------------
// The block takes one text transaction per clock cycle and updates a row of
// match bits held in a chain of per-position cells; the clock period is set by
// the ripple along runs of star positions in that chain. An end-of-text
// transaction yields one match_found result in the following cycle through an
// output register, and new text is taken while that result waits as long as
// the result is being taken in the same cycle. The pattern bytes and length
// are written through the 64-bit register port at byte address 8*i and should
// only be changed between transactions.
module dot_star_pattern_matcher_core #(
	parameter int unsigned PATTERN_MAX = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dspm_pkg::ADDR_W-1:0]   paddr,
	input  logic [dspm_pkg::DATA_W-1:0]   pwdata,
	output logic [dspm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [7:0]                    text_char,
	input  logic                          has_char,
	input  logic                          end_of_text,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          match_found
);
	import dspm_pkg::*;

	localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

	logic [DATA_W-1:0]       pat_regs_q [PAT_REGS];
	logic [LEN_W-1:0]        length_q;
	logic [PATTERN_MAX:0]    match_row_q;
	logic                    string_open_q;
	logic                    result_valid_q;
	logic                    match_found_q;

	logic [8*PAT_BYTES-1:0]  pat_flat;
	logic [LW-1:0]           used_len;
	logic [PATTERN_MAX:0]    base_row;
	logic [PATTERN_MAX:0]    next_row;
	logic [PATTERN_MAX:0]    empty_row;
	logic [PATTERN_MAX:0]    final_row;
	logic                    item_fire;
	logic                    cfg_write;
	reg_index_t              cfg_index;

	// Register port
	assign pready    = 1'b1;
	assign cfg_index = reg_index_t'(paddr[ADDR_W-1:3]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAT_REGS; i++) begin
				pat_regs_q[i] <= '0;
			end
			length_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAT_LOW:      pat_regs_q[0] <= pwdata;
				REG_PAT_MID_LOW:  pat_regs_q[1] <= pwdata;
				REG_PAT_MID_HIGH: pat_regs_q[2] <= pwdata;
				REG_PAT_HIGH:     pat_regs_q[3] <= pwdata;
				REG_PAT_LENGTH:   length_q      <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_index)
			REG_PAT_LOW:      prdata = pat_regs_q[0];
			REG_PAT_MID_LOW:  prdata = pat_regs_q[1];
			REG_PAT_MID_HIGH: prdata = pat_regs_q[2];
			REG_PAT_HIGH:     prdata = pat_regs_q[3];
			REG_PAT_LENGTH:   prdata = {{(DATA_W-LEN_W){1'b0}}, length_q};
			default:          prdata = '0;
		endcase
	end

	// Pattern view for the cell chain
	always_comb begin
		for (int i = 0; i < PAT_REGS; i++) begin
			pat_flat[DATA_W*i +: DATA_W] = pat_regs_q[i];
		end
	end

	// A length beyond the cell count is clamped to the last cell.
	assign used_len = (length_q > LEN_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
	                                                  : LW'(length_q);

	// A new string starts from the empty-text row of the current pattern.
	assign base_row  = string_open_q ? match_row_q : empty_row;
	assign final_row = has_char ? next_row : base_row;

	dspm_row #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_row (
		.pat_bytes (pat_flat[8*PATTERN_MAX-1:0]),
		.used_len  (used_len),
		.text_char (text_char),
		.base_row  (base_row),
		.next_row  (next_row),
		.empty_row (empty_row)
	);

	// Text side and result register
	assign item_ready = !result_valid_q || result_ready;
	assign item_fire  = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_row_q    <= {{PATTERN_MAX{1'b0}}, 1'b1};
			string_open_q  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (item_fire) begin
				match_row_q   <= final_row;
				string_open_q <= !end_of_text;
				if (end_of_text) begin
					result_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire && end_of_text) begin
			match_found_q <= final_row[used_len];
		end
	end

	assign result_valid = result_valid_q;
	assign match_found  = match_found_q;

	// Checks
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && end_of_text |=> result_valid && !string_open_q)
		else $error("end-of-text transaction did not produce a result");

	a_open_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && !end_of_text |=> string_open_q)
		else $error("string not held open after a mid-string transaction");

	a_row_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && has_char |=> !match_row_q[0])
		else $error("empty-prefix bit survived a text byte");

endmodule
